[rtl/stsr_pkg.sv]
// Shared types, constants and helpers for the sorted table block.
// Used by every module in rtl/; depends on nothing.
package stsr_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int TREE_LVLS     = $clog2(TABLE_ENTRIES);
	localparam int TREE_LEAVES   = 1 << TREE_LVLS;
	localparam int WAIT_W        = $clog2(TREE_LVLS) + 1;

	localparam int KEY_W    = 64;
	localparam int PRICE_W  = 17;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 6;
	localparam int KIND_W   = 2;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [PRICE_W-1:0]  price_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [WAIT_W-1:0]   wait_t;

	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_REMOVE = 2'd1;
	localparam kind_t KIND_READ   = 2'd2;

	localparam status_t STATUS_DONE      = 3'd0;
	localparam status_t STATUS_FULL      = 3'd1;
	localparam status_t STATUS_DUPLICATE = 3'd2;
	localparam status_t STATUS_NOT_FOUND = 3'd3;
	localparam status_t STATUS_RANGE     = 3'd4;

	localparam price_t PRICE_MIN = 17'd900;
	localparam price_t PRICE_MAX = 17'd99900;

	typedef struct packed {
		kind_t  kind;
		key_t   key;
		price_t price_cents;
		pos_t   read_index;
	} req_t;

	typedef struct packed {
		status_t status;
		pos_t    position;
		count_t  entry_count;
		price_t  highest_price;
		key_t    entry_key;
		price_t  entry_price;
	} rsp_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic   ins_en;
		logic   rem_en;
		key_t   key;
		price_t price;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_FIN
	} state_t;

	function automatic price_t clamp_price(input price_t p);
		price_t r;
		if (p < PRICE_MIN) begin
			r = PRICE_MIN;
		end else if (p > PRICE_MAX) begin
			r = PRICE_MAX;
		end else begin
			r = p;
		end
		return r;
	endfunction

endpackage

[rtl/sorted_table_insert_remove_max_top.sv]
// Sorted table top level: control sequencer, row of cells, max tree, result register.
// Depends on stsr_pkg, stsr_cell and stsr_max_tree.
//
// Keeps up to TABLE_ENTRIES key/price entries in ascending key order inside a
// row of cells that all compare against the request key at once and shift to
// their neighbors together. A request is captured, applied in the cell row,
// then waits while the registered max tree gives the highest price, and last
// loads the result register once the output is free; no new request is taken
// before then.
// The next request is taken while the previous result still waits on rsp_stall.
// No clearing pass after reset: the entry count alone marks which cells hold data.
module sorted_table_insert_remove_max_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  stsr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output stsr_pkg::rsp_t rsp
);

	stsr_pkg::state_t state_q, state_nxt;
	stsr_pkg::wait_t  wait_q;
	stsr_pkg::cnt_t   count_q;
	stsr_pkg::req_t   req_q;
	stsr_pkg::rsp_t   res_q;
	stsr_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic exec_en, fin_load, out_free, accept;

	stsr_pkg::key_t   cell_key   [stsr_pkg::TABLE_ENTRIES];
	stsr_pkg::price_t cell_price [stsr_pkg::TABLE_ENTRIES];
	stsr_pkg::price_t leaf       [stsr_pkg::TABLE_ENTRIES];
	logic [stsr_pkg::TABLE_ENTRIES-1:0] lt_w, eq_w, ltb_w, occ_w, ins_at_w;

	stsr_pkg::cell_cmd_t cmd;
	stsr_pkg::price_t    max_price;
	stsr_pkg::rsp_t      res_nxt;
	logic                full, dup, found, rd_ok;
	stsr_pkg::pos_t      ins_pos, rem_pos;
	stsr_pkg::key_t      rd_key;
	stsr_pkg::price_t    rd_price;

	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			stsr_pkg::S_IDLE: begin
				if (req_valid) state_nxt = stsr_pkg::S_EXEC;
			end
			stsr_pkg::S_EXEC: begin
				state_nxt = stsr_pkg::S_WAIT;
			end
			stsr_pkg::S_WAIT: begin
				if (int'(wait_q) == stsr_pkg::TREE_LVLS - 1) state_nxt = stsr_pkg::S_FIN;
			end
			stsr_pkg::S_FIN: begin
				if (out_free) state_nxt = stsr_pkg::S_IDLE;
			end
			default: begin
				state_nxt = stsr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		exec_en   = 1'b0;
		fin_load  = 1'b0;
		case (state_q)
			stsr_pkg::S_IDLE: req_stall = 1'b0;
			stsr_pkg::S_EXEC: exec_en = 1'b1;
			stsr_pkg::S_WAIT: ;
			stsr_pkg::S_FIN:  fin_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stsr_pkg::S_IDLE;
			wait_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (exec_en) begin
				wait_q <= '0;
			end else if (state_q == stsr_pkg::S_WAIT) begin
				wait_q <= wait_q + stsr_pkg::wait_t'(1);
			end
		end
	end

	// Capture the request, price already saturated.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.kind        <= req.kind;
			req_q.key         <= req.key;
			req_q.price_cents <= stsr_pkg::clamp_price(req.price_cents);
			req_q.read_index  <= req.read_index;
		end
	end

	// Cell row
	for (genvar i = 0; i < stsr_pkg::TABLE_ENTRIES; i++) begin : g_cell
		assign occ_w[i] = int'(count_q) > i;
		assign leaf[i]  = occ_w[i] ? cell_price[i] : '0;
		if (i == 0) begin : g_first
			assign ltb_w[i] = 1'b1;
		end else begin : g_rest
			assign ltb_w[i] = lt_w[i-1];
		end
		assign ins_at_w[i] = !lt_w[i] && ltb_w[i];

		stsr_pkg::key_t   bk, ak;
		stsr_pkg::price_t bp, ap;
		if (i == 0) begin : g_bot
			assign bk = '0;
			assign bp = '0;
		end else begin : g_bot_n
			assign bk = cell_key[i-1];
			assign bp = cell_price[i-1];
		end
		if (i == stsr_pkg::TABLE_ENTRIES - 1) begin : g_top
			assign ak = '0;
			assign ap = '0;
		end else begin : g_top_n
			assign ak = cell_key[i+1];
			assign ap = cell_price[i+1];
		end

		stsr_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (occ_w[i]),
			.lt_below   (ltb_w[i]),
			.below_key  (bk),
			.below_price(bp),
			.above_key  (ak),
			.above_price(ap),
			.key        (cell_key[i]),
			.price      (cell_price[i]),
			.lt         (lt_w[i]),
			.eq         (eq_w[i])
		);
	end

	assign full  = int'(count_q) == stsr_pkg::TABLE_ENTRIES;
	assign dup   = |eq_w;
	assign found = |eq_w;
	assign rd_ok = int'(req_q.read_index) < int'(count_q);

	always_comb begin
		cmd.ins_en = exec_en && (req_q.kind == stsr_pkg::KIND_INSERT) && !full && !dup;
		cmd.rem_en = exec_en && (req_q.kind == stsr_pkg::KIND_REMOVE) && found;
		cmd.key    = req_q.key;
		cmd.price  = req_q.price_cents;
	end

	// Encode one-hot slot vectors and pick the read entry.
	always_comb begin
		ins_pos  = '0;
		rem_pos  = '0;
		rd_key   = '0;
		rd_price = '0;
		for (int i = 0; i < stsr_pkg::TABLE_ENTRIES; i++) begin
			if (ins_at_w[i]) ins_pos |= stsr_pkg::pos_t'(i);
			if (eq_w[i])     rem_pos |= stsr_pkg::pos_t'(i);
			if (int'(req_q.read_index) == i) begin
				rd_key   |= cell_key[i];
				rd_price |= cell_price[i];
			end
		end
	end

	always_comb begin
		res_nxt = '0;
		case (req_q.kind)
			stsr_pkg::KIND_INSERT: begin
				if (full) begin
					res_nxt.status = stsr_pkg::STATUS_FULL;
				end else if (dup) begin
					res_nxt.status = stsr_pkg::STATUS_DUPLICATE;
				end else begin
					res_nxt.position = ins_pos;
				end
			end
			stsr_pkg::KIND_REMOVE: begin
				if (found) begin
					res_nxt.position = rem_pos;
				end else begin
					res_nxt.status = stsr_pkg::STATUS_NOT_FOUND;
				end
			end
			stsr_pkg::KIND_READ: begin
				if (rd_ok) begin
					res_nxt.position    = req_q.read_index;
					res_nxt.entry_key   = rd_key;
					res_nxt.entry_price = rd_price;
				end else begin
					res_nxt.status = stsr_pkg::STATUS_RANGE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_en) begin
			count_q <= count_q + stsr_pkg::cnt_t'(1);
		end else if (cmd.rem_en) begin
			count_q <= count_q - stsr_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) res_q <= res_nxt;
	end

	stsr_max_tree u_max (
		.clk (clk),
		.leaf(leaf),
		.root(max_price)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			rsp_q.status        <= res_q.status;
			rsp_q.position      <= res_q.position;
			rsp_q.entry_count   <= stsr_pkg::count_t'(count_q);
			rsp_q.highest_price <= max_price;
			rsp_q.entry_key     <= res_q.entry_key;
			rsp_q.entry_price   <= res_q.entry_price;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/stsr_cell.sv]
// One slot of the sorted row: holds a key and a price, compares against the
// broadcast key and shifts to or from its neighbors. Depends on stsr_pkg.
module stsr_cell (
	input  logic                clk,
	input  stsr_pkg::cell_cmd_t cmd,
	input  logic                occ,
	input  logic                lt_below,
	input  stsr_pkg::key_t      below_key,
	input  stsr_pkg::price_t    below_price,
	input  stsr_pkg::key_t      above_key,
	input  stsr_pkg::price_t    above_price,
	output stsr_pkg::key_t      key,
	output stsr_pkg::price_t    price,
	output logic                lt,
	output logic                eq
);

	stsr_pkg::key_t   key_q;
	stsr_pkg::price_t price_q;

	always_comb begin
		lt = occ && (key_q < cmd.key);
		eq = occ && (key_q == cmd.key);
	end

	// Insert: cells at or past the slot move up, the slot itself takes the new entry.
	// Remove: cells at or past the match take the entry above.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !lt) begin
			if (lt_below) begin
				key_q   <= cmd.key;
				price_q <= cmd.price;
			end else begin
				key_q   <= below_key;
				price_q <= below_price;
			end
		end else if (cmd.rem_en && occ && !lt) begin
			key_q   <= above_key;
			price_q <= above_price;
		end
	end

	assign key   = key_q;
	assign price = price_q;

endmodule

[rtl/stsr_max_tree.sv]
// Registered binary max tree over the cell prices, one register level per stage.
// Depends on stsr_pkg.
module stsr_max_tree (
	input  logic             clk,
	input  stsr_pkg::price_t leaf [stsr_pkg::TABLE_ENTRIES],
	output stsr_pkg::price_t root
);

	stsr_pkg::price_t node_q [1:stsr_pkg::TREE_LEAVES-1];

	for (genvar j = 1; j < stsr_pkg::TREE_LEAVES; j++) begin : g_node
		stsr_pkg::price_t a;
		stsr_pkg::price_t b;
		if (2 * j >= stsr_pkg::TREE_LEAVES) begin : g_leaf
			if (2 * j - stsr_pkg::TREE_LEAVES < stsr_pkg::TABLE_ENTRIES) begin : g_a
				assign a = leaf[2 * j - stsr_pkg::TREE_LEAVES];
			end else begin : g_a0
				assign a = '0;
			end
			if (2 * j + 1 - stsr_pkg::TREE_LEAVES < stsr_pkg::TABLE_ENTRIES) begin : g_b
				assign b = leaf[2 * j + 1 - stsr_pkg::TREE_LEAVES];
			end else begin : g_b0
				assign b = '0;
			end
		end else begin : g_inner
			assign a = node_q[2 * j];
			assign b = node_q[2 * j + 1];
		end
		always_ff @(posedge clk) begin
			node_q[j] <= (a > b) ? a : b;
		end
	end

	assign root = node_q[1];

endmodule

[rtl/stsr_checker.sv]
// Port-level checks for the sorted table top level, attached by bind.
// Depends on stsr_pkg and sorted_table_insert_remove_max_top.
module stsr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input stsr_pkg::rsp_t rsp
);

	// Hold a stalled result.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// One request at a time: stall right after taking one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> int'(rsp.entry_count) <= stsr_pkg::TABLE_ENTRIES)
		else $error("entry count beyond table size");

	// Failed requests report position and entry as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != stsr_pkg::STATUS_DONE |->
			rsp.position == '0 && rsp.entry_key == '0 && rsp.entry_price == '0)
		else $error("failed request with nonzero position or entry");

	a_empty_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.entry_count == '0 |-> rsp.highest_price == '0)
		else $error("empty table with nonzero highest price");

endmodule

bind sorted_table_insert_remove_max_top stsr_checker u_stsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

[test/sorted_table_insert_remove_max_top_tb.sv]
// Testbench for the sorted table: directed and random insert, remove and read requests.
// A behavioral copy of the table predicts each result. Depends on stsr_pkg and the top level.
module sorted_table_insert_remove_max_top_tb;

	localparam int              WATCHDOG_LIMIT = 5000;
	localparam int              HOLD_LEN       = 400;
	localparam int              DRAIN_CYCLES   = 24;
	localparam stsr_pkg::kind_t KIND_UNUSED    = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	stsr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	stsr_pkg::rsp_t rsp;

	// Behavioral table: ascending keys in positions 0 .. held_count-1.
	stsr_pkg::key_t   held_key [stsr_pkg::TABLE_ENTRIES];
	stsr_pkg::price_t held_price [stsr_pkg::TABLE_ENTRIES];
	int               held_count = 0;

	stsr_pkg::rsp_t pending_results [$];
	int   mismatch_count = 0;
	int   requests_sent = 0;
	int   results_seen = 0;
	int   peak_count = 0;
	int   status_seen [8];
	int   send_idle_pct = 0;
	int   rsp_stall_pct = 0;
	int   hold_seq = 0;
	int   hold_seq_seen = 0;
	int   hold_left = 0;

	sorted_table_insert_remove_max_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// Apply one request to the behavioral table and return the result it should give.
	function automatic stsr_pkg::rsp_t apply_table_op(input stsr_pkg::req_t r);
		stsr_pkg::rsp_t   res;
		int               slot;
		int               at;
		bit               dup;
		bit               found;
		stsr_pkg::price_t p;
		res = '0;
		case (r.kind)
			stsr_pkg::KIND_INSERT: begin
				if (held_count >= stsr_pkg::TABLE_ENTRIES) begin
					res.status = stsr_pkg::STATUS_FULL;
				end else begin
					dup = 1'b0;
					slot = 0;
					for (int i = 0; i < held_count; i++) begin
						if (held_key[i] == r.key) dup = 1'b1;
						if (held_key[i] < r.key) slot++;
					end
					if (dup) begin
						res.status = stsr_pkg::STATUS_DUPLICATE;
					end else begin
						// saturate the price into the legal band
						if (r.price_cents < stsr_pkg::PRICE_MIN) begin
							p = stsr_pkg::PRICE_MIN;
						end else if (r.price_cents > stsr_pkg::PRICE_MAX) begin
							p = stsr_pkg::PRICE_MAX;
						end else begin
							p = r.price_cents;
						end
						for (int i = held_count; i > slot; i--) begin
							held_key[i] = held_key[i-1];
							held_price[i] = held_price[i-1];
						end
						held_key[slot] = r.key;
						held_price[slot] = p;
						held_count++;
						res.position = stsr_pkg::pos_t'(slot);
					end
				end
			end
			stsr_pkg::KIND_REMOVE: begin
				found = 1'b0;
				at = 0;
				for (int i = 0; i < held_count; i++) begin
					if (!found && held_key[i] == r.key) begin
						found = 1'b1;
						at = i;
					end
				end
				if (!found) begin
					res.status = stsr_pkg::STATUS_NOT_FOUND;
				end else begin
					for (int i = at; i + 1 < held_count; i++) begin
						held_key[i] = held_key[i+1];
						held_price[i] = held_price[i+1];
					end
					held_count--;
					res.position = stsr_pkg::pos_t'(at);
				end
			end
			stsr_pkg::KIND_READ: begin
				if (int'(r.read_index) < held_count) begin
					res.position = r.read_index;
					res.entry_key = held_key[r.read_index];
					res.entry_price = held_price[r.read_index];
				end else begin
					res.status = stsr_pkg::STATUS_RANGE;
				end
			end
			default: begin
				// unused kind leaves the table alone
			end
		endcase
		res.entry_count = stsr_pkg::count_t'(held_count);
		res.highest_price = '0;
		for (int i = 0; i < held_count; i++) begin
			if (held_price[i] > res.highest_price) res.highest_price = held_price[i];
		end
		return res;
	endfunction

	function automatic stsr_pkg::req_t make_req(input stsr_pkg::kind_t kind,
			input stsr_pkg::key_t key, input stsr_pkg::price_t price,
			input stsr_pkg::pos_t idx);
		stsr_pkg::req_t r;
		r.kind = kind;
		r.key = key;
		r.price_cents = price;
		r.read_index = idx;
		return r;
	endfunction

	// Short lowercase name packed big-endian and zero padded; small alphabet to collide.
	function automatic stsr_pkg::key_t name_key();
		stsr_pkg::key_t k;
		int             len;
		k = '0;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			k[63 - 8*i -: 8] = 8'h61 + 8'($urandom_range(0, 3));
		end
		return k;
	endfunction

	function automatic stsr_pkg::req_t random_request(input int insert_pct);
		stsr_pkg::req_t r;
		int             pick;
		int             keysel;
		int             reuse_pct;
		pick = $urandom_range(0, 99);
		if (pick < insert_pct) begin
			r.kind = stsr_pkg::KIND_INSERT;
		end else if (pick >= 97) begin
			r.kind = KIND_UNUSED;
		end else if ($urandom_range(0, 1)) begin
			r.kind = stsr_pkg::KIND_REMOVE;
		end else begin
			r.kind = stsr_pkg::KIND_READ;
		end
		reuse_pct = (r.kind == stsr_pkg::KIND_INSERT) ? 20 : 60;
		keysel = $urandom_range(0, 99);
		if (keysel < reuse_pct && held_count > 0) begin
			r.key = held_key[$urandom_range(0, held_count - 1)];
		end else if (keysel < 85) begin
			r.key = name_key();
		end else begin
			r.key = {$urandom, $urandom};
		end
		if ($urandom_range(0, 99) < 85) begin
			r.price_cents = stsr_pkg::price_t'($urandom_range(int'(stsr_pkg::PRICE_MIN),
				int'(stsr_pkg::PRICE_MAX)));
		end else begin
			r.price_cents = stsr_pkg::price_t'($urandom_range(0, 131071));
		end
		if (held_count > 0 && $urandom_range(0, 99) < 80) begin
			r.read_index = stsr_pkg::pos_t'($urandom_range(0, held_count - 1));
		end else begin
			r.read_index = stsr_pkg::pos_t'($urandom_range(0, 31));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH @%0t %s: got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_result(input stsr_pkg::rsp_t got);
		stsr_pkg::rsp_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending, status", 64'(got.status), 64'd0);
		end else begin
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.position !== want.position)
				report_mismatch("position", 64'(got.position), 64'(want.position));
			if (got.entry_count !== want.entry_count)
				report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
			if (got.highest_price !== want.highest_price)
				report_mismatch("highest_price", 64'(got.highest_price),
					64'(want.highest_price));
			if (got.entry_key !== want.entry_key)
				report_mismatch("entry_key", got.entry_key, want.entry_key);
			if (got.entry_price !== want.entry_price)
				report_mismatch("entry_price", 64'(got.entry_price), 64'(want.entry_price));
		end
	endtask

	// Offer one request; valid stays high after acceptance unless a gap follows.
	task automatic send_request(input stsr_pkg::req_t r);
		stsr_pkg::rsp_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		want = apply_table_op(r);
		pending_results.push_back(want);
		status_seen[want.status]++;
		requests_sent++;
		if (held_count > peak_count) peak_count = held_count;
	endtask

	// Receiver: check accepted results, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) check_result(rsp);
		if (hold_seq != hold_seq_seen) begin
			hold_seq_seen = hold_seq;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic test_directed_cases();
		send_request(make_req(stsr_pkg::KIND_READ, '0, stsr_pkg::PRICE_MIN, 5'd0));
		send_request(make_req(stsr_pkg::KIND_REMOVE, 64'h7a7a_0000_0000_0000,
			stsr_pkg::PRICE_MIN, 5'd0));
		send_request(make_req(stsr_pkg::KIND_INSERT, '0, 17'd0, 5'd0));
		send_request(make_req(stsr_pkg::KIND_INSERT, '1, 17'h1FFFF, 5'd31));
		send_request(make_req(stsr_pkg::KIND_INSERT, 64'h6d00_0000_0000_0000,
			stsr_pkg::PRICE_MIN, 5'd0));
		send_request(make_req(stsr_pkg::KIND_INSERT, 64'h6d00_0000_0000_0000, 17'd5000,
			5'd0));
		send_request(make_req(stsr_pkg::KIND_INSERT, 64'h6200_0000_0000_0000,
			stsr_pkg::PRICE_MAX, 5'd0));
		send_request(make_req(stsr_pkg::KIND_INSERT, 64'h6d6d_0000_0000_0000, 17'd899,
			5'd0));
		send_request(make_req(stsr_pkg::KIND_INSERT, 64'h7a00_0000_0000_0000, 17'd99901,
			5'd0));
		for (int i = 0; i < 5; i++) begin
			send_request(make_req(stsr_pkg::KIND_READ, '0, '0, stsr_pkg::pos_t'(i)));
		end
		send_request(make_req(stsr_pkg::KIND_READ, '1, '1, 5'd31));
		send_request(make_req(KIND_UNUSED, {$urandom, $urandom}, '1, 5'd17));
		// drop the top and bottom keys, miss one, then take from the middle
		send_request(make_req(stsr_pkg::KIND_REMOVE, '1, '0, 5'd0));
		send_request(make_req(stsr_pkg::KIND_REMOVE, '0, '0, 5'd0));
		send_request(make_req(stsr_pkg::KIND_REMOVE, 64'h7100_0000_0000_0000, '0, 5'd0));
		send_request(make_req(stsr_pkg::KIND_READ, '0, '0, 5'd0));
		send_request(make_req(stsr_pkg::KIND_REMOVE, 64'h6d00_0000_0000_0000, '0, 5'd0));
	endtask

	task automatic test_full_table();
		int n;
		n = 0;
		while (held_count < stsr_pkg::TABLE_ENTRIES) begin
			send_request(make_req(stsr_pkg::KIND_INSERT, {8'h70, 56'(n * 7919)},
				stsr_pkg::price_t'($urandom_range(int'(stsr_pkg::PRICE_MIN),
				int'(stsr_pkg::PRICE_MAX))), '0));
			n++;
		end
		// full is reported ahead of duplicate
		send_request(make_req(stsr_pkg::KIND_INSERT, 64'h0100_0000_0000_0000,
			stsr_pkg::PRICE_MIN, '0));
		send_request(make_req(stsr_pkg::KIND_INSERT, held_key[5], stsr_pkg::PRICE_MIN, '0));
		send_request(make_req(stsr_pkg::KIND_READ, '0, '0, 5'd31));
		send_request(make_req(stsr_pkg::KIND_READ, '0, '0, 5'd0));
		send_request(make_req(stsr_pkg::KIND_REMOVE, held_key[stsr_pkg::TABLE_ENTRIES-1],
			'0, '0));
		send_request(make_req(stsr_pkg::KIND_READ, '0, '0, 5'd31));
		send_request(make_req(stsr_pkg::KIND_REMOVE, held_key[0], '0, '0));
	endtask

	// Hold the output for a long stretch while requests keep coming.
	task automatic test_output_backpressure(input int count);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_seq <= hold_seq + 1;
		for (int i = 0; i < count; i++) send_request(random_request(45));
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct,
			input int stall_pct, input int insert_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) send_request(random_request(insert_pct));
	endtask

	initial begin
		for (int i = 0; i < 8; i++) status_seen[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_table();
		test_output_backpressure(30);
		test_random_traffic(200, 0, 0, 60);
		test_random_traffic(180, 80, 0, 45);
		test_random_traffic(180, 0, 80, 30);
		test_random_traffic(200, 22, 22, 50);
		test_random_traffic(150, 0, 0, 40);

		req_valid <= 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d results checked, table peaked at %0d of %0d",
			requests_sent, results_seen, peak_count, stsr_pkg::TABLE_ENTRIES);
		$display("status mix: done %0d, full %0d, duplicate %0d, not found %0d, range %0d",
			status_seen[stsr_pkg::STATUS_DONE], status_seen[stsr_pkg::STATUS_FULL],
			status_seen[stsr_pkg::STATUS_DUPLICATE], status_seen[stsr_pkg::STATUS_NOT_FOUND],
			status_seen[stsr_pkg::STATUS_RANGE]);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
